FILE: design/modbus_ascii_request_framer_defines.svh
// assertion macros for the modbus ascii request framer
// no dependencies; taken in by the checker file
`ifndef MODBUS_ASCII_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_ASCII_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MBAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbaf assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define MBAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbaf assertion failed");

`endif

FILE: design/mbaf_pkg.sv
// shared types, constants and character function for the modbus ascii framer
// no dependencies
package mbaf_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_DIGIT_BASE = 8'h30;
   localparam logic [7:0] CHAR_ALPHA_BASE = 8'h37;
   localparam logic [3:0] NIBBLE_TEN      = 4'd10;

   localparam logic [4:0] CHAR_POS_START = 5'd0;
   localparam logic [4:0] CHAR_POS_CR    = 5'd15;
   localparam logic [4:0] CHAR_POS_LF    = 5'd16;
   localparam logic [4:0] CHAR_POS_TOP   = 5'd14;

   typedef struct packed {
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [15:0] register_value;
      logic [7:0]  lrc;
   } frame_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   function automatic logic [7:0] frame_char(logic [4:0] pos, frame_type frame);
      logic [55:0] bits;
      logic [3:0]  idx;
      logic [3:0]  nib;
      logic [7:0]  ch;
      bits = frame;
      idx  = 4'(CHAR_POS_TOP - pos);
      nib  = bits[{idx, 2'b00} +: 4];
      if (pos == CHAR_POS_START) begin
         ch = CHAR_COLON;
      end else if (pos == CHAR_POS_CR) begin
         ch = CHAR_CR;
      end else if (pos >= CHAR_POS_LF) begin
         ch = CHAR_LF;
      end else if (nib < NIBBLE_TEN) begin
         ch = CHAR_DIGIT_BASE + {4'h0, nib};
      end else begin
         ch = CHAR_ALPHA_BASE + {4'h0, nib};
      end
      return ch;
   endfunction

endpackage

FILE: design/modbus_ascii_request_framer.sv
// top level of the modbus ascii request framer: front end, frame queue, serializer
// depends on mbaf_pkg, mbaf_front, mbaf_queue, mbaf_back
//
//   port group  direction  word
//   req_        in         function code, register address, register value
//   rsp_        out        one frame character, last-character flag
//   csr_        in         slave address write
//
// a request yields 17 chars, one per ready cycle from the serializer output register
// frames follow back to back: the next request is taken while one is still being sent
// the queue holds QUEUE_DEPTH requests; req_ready drops only when it is full
// rsp_ready low holds the current character and stalls the serializer alone
// reset is synchronous; slave address resets to 1
module modbus_ascii_request_framer #(
   parameter int QUEUE_DEPTH = mbaf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_register_address,
   input  logic [15:0] req_register_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char
);

   mbaf_pkg::queue_status_type queue_status;
   mbaf_pkg::frame_type        push_frame;
   mbaf_pkg::frame_type        head_frame;
   logic                       push;
   logic                       pop;

   mbaf_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_function_code    (req_function_code),
      .req_register_address (req_register_address),
      .req_register_value   (req_register_value),
      .queue_status         (queue_status),
      .push                 (push),
      .push_frame           (push_frame)
   );

   mbaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .status     (queue_status),
      .head_frame (head_frame)
   );

   mbaf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .head_frame    (head_frame),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: design/mbaf_front.sv
// request front end: slave address register, byte assembly and lrc
// depends on mbaf_pkg
module mbaf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [7:0]                 csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_function_code,
   input  logic [15:0]                req_register_address,
   input  logic [15:0]                req_register_value,
   input  mbaf_pkg::queue_status_type queue_status,
   output logic                       push,
   output mbaf_pkg::frame_type        push_frame
);

   logic [7:0] slave_address_ff;
   logic [7:0] slave_address_in;
   logic [7:0] byte_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= mbaf_pkg::SLAVE_ADDRESS_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   always_comb begin
      slave_address_in = csr_write_enable ? csr_write_data : slave_address_ff;
      byte_sum = slave_address_ff + req_function_code
               + req_register_address[15:8] + req_register_address[7:0]
               + req_register_value[15:8] + req_register_value[7:0];
      push_frame.slave_address    = slave_address_ff;
      push_frame.function_code    = req_function_code;
      push_frame.register_address = req_register_address;
      push_frame.register_value   = req_register_value;
      push_frame.lrc              = 8'(8'h00 - byte_sum);
      req_ready = queue_status.not_full;
      push      = req_valid && queue_status.not_full;
   end

endmodule

FILE: design/mbaf_queue.sv
// short frame queue between front end and serializer
// depends on mbaf_pkg
module mbaf_queue #(
   parameter int DEPTH = mbaf_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mbaf_pkg::frame_type        push_frame,
   input  logic                       pop,
   output mbaf_pkg::queue_status_type status,
   output mbaf_pkg::frame_type        head_frame
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbaf_pkg::frame_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
      status.not_empty = (count_ff != '0);
      status.not_full  = (count_ff != CNT_W'(DEPTH));
      head_frame       = entry_ff[rd_ptr_ff];
   end

endmodule

FILE: design/mbaf_back.sv
// character serializer with output register
// depends on mbaf_pkg
module mbaf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mbaf_pkg::queue_status_type queue_status,
   input  mbaf_pkg::frame_type        head_frame,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_char
);

   mbaf_pkg::frame_type frame_ff;
   mbaf_pkg::frame_type frame_in;
   mbaf_pkg::frame_type cur_frame;
   logic [4:0] pos_ff;
   logic [4:0] pos_in;
   logic [4:0] cur_pos;
   logic       busy_ff;
   logic       busy_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_out_char_ff;
   logic [7:0] rsp_out_char_in;
   logic       rsp_last_char_ff;
   logic       rsp_last_char_in;
   logic       slot_free;
   logic       emit;
   logic       is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff         <= frame_in;
      rsp_out_char_ff  <= rsp_out_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      cur_frame = busy_ff ? frame_ff : head_frame;
      cur_pos   = busy_ff ? pos_ff : mbaf_pkg::CHAR_POS_START;
      emit      = slot_free && (busy_ff || queue_status.not_empty);
      pop       = emit && !busy_ff;
      is_last   = (cur_pos == mbaf_pkg::CHAR_POS_LF);

      frame_in         = pop ? head_frame : frame_ff;
      pos_in           = pos_ff;
      busy_in          = busy_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_out_char_in  = rsp_out_char_ff;
      rsp_last_char_in = rsp_last_char_ff;
      if (emit) begin
         pos_in           = is_last ? mbaf_pkg::CHAR_POS_START : 5'(cur_pos + 1'b1);
         busy_in          = !is_last;
         rsp_valid_in     = 1'b1;
         rsp_out_char_in  = mbaf_pkg::frame_char(cur_pos, cur_frame);
         rsp_last_char_in = is_last;
      end

      rsp_valid     = rsp_valid_ff;
      rsp_out_char  = rsp_out_char_ff;
      rsp_last_char = rsp_last_char_ff;
   end

endmodule

FILE: design/mbaf_checker.sv
// port-level checks on the framer output character stream, bound to the top level
// depends on modbus_ascii_request_framer_defines.svh and mbaf_pkg
`include "modbus_ascii_request_framer_defines.svh"

module mbaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   logic frame_start_ff;
   logic frame_start_in;
   logic prev_cr_ff;
   logic prev_cr_in;
   logic rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= 1'b1;
         prev_cr_ff     <= 1'b0;
      end else begin
         frame_start_ff <= frame_start_in;
         prev_cr_ff     <= prev_cr_in;
      end
   end

   always_comb begin
      rsp_word       = rsp_valid && rsp_ready;
      frame_start_in = rsp_word ? rsp_last_char : frame_start_ff;
      prev_cr_in     = rsp_word ? (rsp_out_char == mbaf_pkg::CHAR_CR) : prev_cr_ff;
   end

   // stalled word holds
   `MBAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
   // each frame opens with a colon
   `MBAF_ASSERT_NOW(a_frame_open, clock, reset, rsp_valid && frame_start_ff, rsp_out_char == mbaf_pkg::CHAR_COLON)
   // carriage return is followed by the closing line feed
   `MBAF_ASSERT_NOW(a_cr_then_lf, clock, reset, rsp_valid && prev_cr_ff, rsp_out_char == mbaf_pkg::CHAR_LF && rsp_last_char)
   // the last flag only ever follows a carriage return
   `MBAF_ASSERT_NOW(a_last_after_cr, clock, reset, rsp_valid && rsp_last_char, prev_cr_ff)

endmodule

bind modbus_ascii_request_framer mbaf_checker u_mbaf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);

FILE: tb/sv/modbus_ascii_request_framer_tb.sv
`timescale 1ns / 1ps
// testbench for modbus_ascii_request_framer: requests in, 17-character ascii frames out
// depends on mbaf_pkg and the framer rtl; predicts each frame and checks every word
module modbus_ascii_request_framer_tb;

   localparam int FRAME_LENGTH = 17;

   typedef struct packed {
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [15:0] register_value;
   } modbus_request_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } frame_char_type;

   typedef enum int {
      RECV_STREAM,
      RECV_RANDOM,
      RECV_LONG_HOLD,
      RECV_TOGGLE
   } recv_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_function_code = 8'h00;
   logic [15:0] req_register_address = 16'h0000;
   logic [15:0] req_register_value = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;

   modbus_request_type pending_requests[$];
   frame_char_type     expected_chars[$];

   logic [7:0]  slave_shadow = mbaf_pkg::SLAVE_ADDRESS_RESET;
   logic [55:0] frame_shadow = '0;

   int            error_count = 0;
   int            requests_sent = 0;
   int            chars_checked = 0;
   int            address_settings = 1;
   int            burst_left = 0;
   int            gap_left = 0;
   int            gap_max = 0;
   int            stall_tick = 0;
   recv_mode_type recv_mode = RECV_STREAM;

   modbus_ascii_request_framer u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_function_code    (req_function_code),
      .req_register_address (req_register_address),
      .req_register_value   (req_register_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_char         (rsp_out_char),
      .rsp_last_char        (rsp_last_char)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] ascii_hex(logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return 8'h30 + {4'h0, nibble};
      end
      return 8'h41 + {4'h0, nibble} - 8'd10;
   endfunction

   // builds the frame bytes with lrc and queues all 17 characters
   task automatic predict_frame(input modbus_request_type req);
      logic [7:0]     byte_sum;
      logic [7:0]     lrc;
      frame_char_type fc;
      byte_sum = slave_shadow + req.function_code + req.register_address[15:8]
               + req.register_address[7:0] + req.register_value[15:8]
               + req.register_value[7:0];
      lrc = 8'h00 - byte_sum;
      frame_shadow = {slave_shadow, req.function_code, req.register_address,
                      req.register_value, lrc};
      for (int pos = 0; pos < FRAME_LENGTH; pos++) begin
         if (pos == 0) begin
            fc.out_char = mbaf_pkg::CHAR_COLON;
         end else if (pos == 15) begin
            fc.out_char = mbaf_pkg::CHAR_CR;
         end else if (pos == 16) begin
            fc.out_char = mbaf_pkg::CHAR_LF;
         end else begin
            fc.out_char = ascii_hex(frame_shadow[(14 - pos) * 4 +: 4]);
         end
         fc.last_char = (pos == FRAME_LENGTH - 1);
         expected_chars.push_back(fc);
      end
   endtask

   // sender: bursts of words with random gaps
   always @(posedge clock) begin : drive_proc
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame(pending_requests.pop_front());
            requests_sent++;
            if (burst_left > 0) begin
               burst_left--;
            end
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               if (gap_max == 0 || $urandom_range(0, 2) == 0) begin
                  gap_left = 0;
               end else begin
                  gap_left = $urandom_range(1, gap_max);
               end
            end
         end
         if (req_valid && !req_ready) begin
            // hold word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_valid            <= 1'b1;
            req_function_code    <= pending_requests[0].function_code;
            req_register_address <= pending_requests[0].register_address;
            req_register_value   <= pending_requests[0].register_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, reselected at random among stream, random, long-hold and toggle modes
   always @(posedge clock) begin : stall_proc
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 300 == 0) begin
            recv_mode = recv_mode_type'($urandom_range(0, 3));
         end
         case (recv_mode)
            RECV_STREAM: begin
               rsp_ready <= 1'b1;
            end
            RECV_RANDOM: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            RECV_LONG_HOLD: begin
               rsp_ready <= (stall_tick % 32 >= 12);
            end
            default: begin
               rsp_ready <= stall_tick[0];
            end
         endcase
      end
   end

   always @(posedge clock) begin : watch_proc
      frame_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected word: out_char %h last_char %b", rsp_out_char, rsp_last_char);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_out_char !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_out_char);
               error_count++;
            end
            if (rsp_last_char !== want.last_char) begin
               $error("last_char: expected %b, got %b", want.last_char, rsp_last_char);
               error_count++;
            end
         end
      end
   end

   task automatic add_request(input logic [7:0] fc, input logic [15:0] ra,
                              input logic [15:0] rv);
      modbus_request_type req;
      req.function_code    = fc;
      req.register_address = ra;
      req.register_value   = rv;
      pending_requests.push_back(req);
   endtask

   function automatic logic [15:0] random_word();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return 16'h0000;
      end else if (pick == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   // mostly read and write register requests, the rest any function byte
   task automatic add_random_requests(input int count);
      logic [7:0] fc;
      int         pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            fc = 8'h03;
         end else if (pick < 6) begin
            fc = 8'h06;
         end else begin
            fc = 8'($urandom);
         end
         add_request(fc, random_word(), random_word());
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_valid || expected_chars.size() != 0);
   endtask

   task automatic write_slave_address(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slave_shadow = value;
      address_settings++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset slave address, directed corners
      gap_max = 6;
      add_request(8'h00, 16'h0000, 16'h0000);
      add_request(8'hFF, 16'hFFFF, 16'hFFFF);
      add_request(8'h03, 16'h0000, 16'h0001);
      add_request(8'h06, 16'h1234, 16'hABCD);
      add_request(8'hFF, 16'h0000, 16'h0000);   // lrc of zero
      add_request(8'h5A, 16'hA5C3, 16'h3CF0);
      add_request(8'h10, 16'h89AB, 16'hCDEF);
      add_request(8'h80, 16'h8000, 16'h0080);
      add_request(8'h01, 16'h00FF, 16'hFF00);
      add_request(8'h7F, 16'h7FFF, 16'h7FFF);
      add_request(8'h06, 16'hFEDC, 16'hBA98);
      wait_idle();

      write_slave_address(8'h00);
      gap_max = 0;
      add_request(8'h00, 16'h0000, 16'h0000);   // all-zero frame
      add_request(8'hFF, 16'hFFFF, 16'hFFFF);
      add_request(8'h03, 16'h0001, 16'h007D);
      add_request(8'h06, 16'h0100, 16'hFFFE);
      add_random_requests(30);
      wait_idle();

      write_slave_address(8'hFF);
      gap_max = 30;
      add_request(8'hFF, 16'hFFFF, 16'hFFFF);
      add_request(8'h01, 16'h0000, 16'h0000);   // lrc of zero
      add_request(8'h03, 16'hC000, 16'h0010);
      add_request(8'h06, 16'h0000, 16'h8001);
      add_random_requests(30);
      wait_idle();

      write_slave_address(8'($urandom_range(2, 254)));
      gap_max = 4;
      add_random_requests(30);
      wait_idle();

      write_slave_address(8'($urandom));
      gap_max = 20;
      add_random_requests(30);
      wait_idle();

      write_slave_address(8'h01);
      gap_max = 0;
      add_random_requests(30);
      wait_idle();

      repeat (40) @(posedge clock);
      $display("framed %0d requests under %0d slave addresses, %0d words checked",
               requests_sent, address_settings, chars_checked);
      $display("%0d mismatches, %0d words still expected", error_count, expected_chars.size());
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
